// File: rtl/npps_pkg.sv
// Shared constants, codes and types of the nearest path point search block.
package npps_pkg;

  // Store and sampling limits
  localparam int MAX_POINTS  = 256;
  localparam int MAX_SAMPLES = 1024;

  // Field widths
  localparam int IDX_W     = 8;
  localparam int LEN_W     = 9;
  localparam int DENS_W    = 11;
  localparam int COORD_W   = 32;
  localparam int DSQ_W     = 65;
  localparam int CMP_W     = 66;
  localparam int NS_W      = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATH_LENGTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DENSITY = 1'b1;

  localparam logic [DENS_W-1:0] DENSITY_RESET = 11'd100;

  // Request type codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Classified request handed from front to back
  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } item_t;

  // Tag that travels with a point through the distance pipeline
  typedef struct packed {
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } tag_t;

  // One query result
  typedef struct packed {
    logic                      found;
    logic                      single_point;
    logic signed [COORD_W-1:0] result_x;
    logic signed [COORD_W-1:0] result_y;
    logic [IDX_W-1:0]          nearest_waypoint_index;
    logic [IDX_W-1:0]          second_waypoint_index;
    logic                      nearest_above_second;
  } result_t;

endpackage

// File: rtl/npps_if.sv
// Valid/ready channel interfaces for request and result transactions.
interface npps_in_if;
  import npps_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [IDX_W-1:0]          waypoint_index;
  logic signed [COORD_W-1:0] ref_x;
  logic signed [COORD_W-1:0] ref_y;

  modport source (output valid, req_type, waypoint_index, ref_x, ref_y, input ready);
  modport sink   (input valid, req_type, waypoint_index, ref_x, ref_y, output ready);
endinterface

interface npps_out_if;
  import npps_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic                      single_point;
  logic signed [COORD_W-1:0] result_x;
  logic signed [COORD_W-1:0] result_y;
  logic [IDX_W-1:0]          nearest_waypoint_index;
  logic [IDX_W-1:0]          second_waypoint_index;
  logic                      nearest_above_second;

  modport source (output valid, found, single_point, result_x, result_y,
                  nearest_waypoint_index, second_waypoint_index, nearest_above_second,
                  input ready);
  modport sink   (input valid, found, single_point, result_x, result_y,
                  nearest_waypoint_index, second_waypoint_index, nearest_above_second,
                  output ready);
endinterface

// File: rtl/npps_front.sv
// Front end: accepts request transactions, classifies them and queues them.
module npps_front (
  input  logic            clk,
  input  logic            rst_n,
  npps_in_if.sink         in_if,
  output npps_pkg::item_t item,
  output logic            item_valid,
  input  logic            item_ready
);
  import npps_pkg::*;

  item_t       q_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  count_r;
  logic        push;
  logic        pop;
  item_t       in_item;

  // Classify the incoming request
  always_comb begin
    in_item.idx = in_if.waypoint_index;
    in_item.x   = in_if.ref_x;
    in_item.y   = in_if.ref_y;
    case (in_if.req_type)
      OP_QUERY: in_item.op = OP_QUERY;
      default:  in_item.op = OP_WRITE;
    endcase
  end

  assign in_if.ready = (count_r != 2'd2);
  assign item_valid  = (count_r != 2'd0);
  assign item        = q_r[rp_r];
  assign push        = in_if.valid && in_if.ready;
  assign pop         = item_valid && item_ready;

  // Hold queued transactions until the back end takes them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wp_r] <= in_item;
        wp_r      <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/npps_dist.sv
// Three-stage pipeline computing exact squared Euclidean distance of two points.
module npps_dist (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [npps_pkg::COORD_W-1:0] ax,
  input  logic signed [npps_pkg::COORD_W-1:0] ay,
  input  logic signed [npps_pkg::COORD_W-1:0] bx,
  input  logic signed [npps_pkg::COORD_W-1:0] by,
  input  npps_pkg::tag_t                      in_tag,
  output logic                                out_valid,
  output logic [npps_pkg::DSQ_W-1:0]          out_dist,
  output npps_pkg::tag_t                      out_tag
);
  import npps_pkg::*;

  logic signed [COORD_W:0]   dx;
  logic signed [COORD_W:0]   dy;
  logic [COORD_W:0]          mx;
  logic [COORD_W:0]          my;
  logic [COORD_W-1:0]        ux_r, uy_r;
  logic [2*COORD_W-1:0]      sx_r, sy_r;
  logic [DSQ_W-1:0]          sum_r;
  logic [2:0]                v_r;
  tag_t                      t1_r, t2_r, t3_r;

  // Magnitudes of the coordinate differences
  always_comb begin
    dx = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
    dy = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
    mx = dx[COORD_W] ? -dx : dx;
    my = dy[COORD_W] ? -dy : dy;
  end

  // Advance: magnitude, square, sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 3'b000;
    end else begin
      v_r <= {v_r[1:0], in_valid};
    end
    ux_r  <= mx[COORD_W-1:0];
    uy_r  <= my[COORD_W-1:0];
    t1_r  <= in_tag;
    sx_r  <= ux_r * ux_r;
    sy_r  <= uy_r * uy_r;
    t2_r  <= t1_r;
    sum_r <= {1'b0, sx_r} + {1'b0, sy_r};
    t3_r  <= t2_r;
  end

  assign out_valid = v_r[2];
  assign out_dist  = sum_r;
  assign out_tag   = t3_r;

endmodule

// File: rtl/npps_back.sv
// Back end: path store, waypoint scan, segment sizing and sample search.
module npps_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  npps_pkg::item_t                item,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [npps_pkg::LEN_W-1:0]     path_length,
  input  logic [npps_pkg::DENS_W-1:0]    sample_density,
  output npps_pkg::result_t              res,
  output logic                           res_valid,
  input  logic                           res_ready
);
  import npps_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_SEG   = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_NCALC = 4'd4;
  localparam logic [3:0] S_NSAT  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_SAMP  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam int REM_W  = 36;
  localparam int ROOT_W = 33;
  localparam int NUM_W  = COORD_W + 1;
  localparam int DV_W   = NS_W + 1;
  localparam int PROD_W = ROOT_W + DENS_W;
  localparam logic [CMP_W-1:0] DIST_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_POINTS);
  localparam logic [NS_W-1:0]  NS_MAX   = NS_W'(MAX_SAMPLES);

  logic [3:0]                state_r;
  logic [2*COORD_W-1:0]      mem [MAX_POINTS];
  logic [2*COORD_W-1:0]      rd_data_r;
  logic                      rd_v_r;
  logic [IDX_W-1:0]          rd_idx_r;

  logic signed [COORD_W-1:0] qx_r, qy_r;
  logic [LEN_W-1:0]          len_r;
  logic [NS_W-1:0]           cnt_r, rc_r;
  logic [CMP_W-1:0]          cd_r, sd_r, bd_r;
  logic [IDX_W-1:0]          ci_r, si_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, sx_r, sy_r, bx_r, by_r;

  logic [CMP_W-1:0]          rad_r;
  logic [REM_W-1:0]          rem_r;
  logic [ROOT_W-1:0]         root_r;
  logic [5:0]                step_r;
  logic [PROD_W-1:0]         prod_r;
  logic [NS_W-1:0]           n_r;

  logic [NUM_W-1:0]          numx_r, numy_r, quox_r, quoy_r;
  logic [DV_W-1:0]           drx_r, dry_r;
  logic                      negx_r, negy_r;
  logic [NUM_W-1:0]          accx_r, accy_r;
  logic [DV_W:0]             smx_r, smy_r;

  result_t                   pend_r;
  result_t                   res_r;
  logic                      res_valid_r;

  // Distance pipeline hookup
  logic                      d_in_valid;
  logic signed [COORD_W-1:0] d_ax, d_ay, d_bx, d_by;
  tag_t                      d_tag;
  logic                      d_out_valid;
  logic [DSQ_W-1:0]          d_out_dist;
  tag_t                      d_out_tag;
  logic [CMP_W-1:0]          d66;

  logic                      scan_issue;
  logic                      samp_issue;
  logic [IDX_W-1:0]          rd_addr;

  // Combinational helpers
  logic [REM_W-1:0]          rem_t, trial;
  logic                      rem_ge;
  logic [PROD_W-1:0]         prod_rnd;
  logic [PROD_W-17:0]        n_raw;
  logic [NS_W-1:0]           n_sat;
  logic signed [COORD_W:0]   sdx, sdy;
  logic [COORD_W:0]          amx, amy;
  logic [DV_W-1:0]           dvsr;
  logic [DV_W:0]             rrx, rry;
  logic [DV_W:0]             stx, sty;
  logic signed [NUM_W:0]     smpx_w, smpy_w;
  logic signed [COORD_W-1:0] smp_x, smp_y;

  assign d66       = {1'b0, d_out_dist};
  assign rd_addr   = cnt_r[IDX_W-1:0];
  assign scan_issue = (state_r == S_SCAN) && (cnt_r < {2'b0, len_r});
  assign samp_issue = (state_r == S_SAMP) && (cnt_r <= n_r);
  assign item_ready = (state_r == S_IDLE);

  // Square root step: shift in two radicand bits, try subtract
  always_comb begin
    rem_t  = {rem_r[REM_W-3:0], rad_r[CMP_W-1:CMP_W-2]};
    trial  = {1'b0, root_r, 2'b01};
    rem_ge = (rem_t >= trial);
  end

  // Sample count: round, clamp to one..MAX_SAMPLES
  always_comb begin
    prod_rnd = prod_r + PROD_W'(32768);
    n_raw    = prod_rnd[PROD_W-1:16];
    if (n_raw == '0) n_sat = NS_W'(1);
    else if (n_raw > (PROD_W-16)'(MAX_SAMPLES)) n_sat = NS_MAX;
    else n_sat = n_raw[NS_W-1:0];
  end

  // Segment deltas and division steps
  always_comb begin
    sdx  = {sx_r[COORD_W-1], sx_r} - {cx_r[COORD_W-1], cx_r};
    sdy  = {sy_r[COORD_W-1], sy_r} - {cy_r[COORD_W-1], cy_r};
    amx  = sdx[COORD_W] ? -sdx : sdx;
    amy  = sdy[COORD_W] ? -sdy : sdy;
    dvsr = {n_r, 1'b0};
    rrx  = {drx_r, numx_r[NUM_W-1]};
    rry  = {dry_r, numy_r[NUM_W-1]};
    stx  = smx_r + {1'b0, drx_r};
    sty  = smy_r + {1'b0, dry_r};
  end

  // Interior sample point from the running quotient
  always_comb begin
    smpx_w = negx_r ? ({{2{cx_r[COORD_W-1]}}, cx_r} - {1'b0, accx_r})
                    : ({{2{cx_r[COORD_W-1]}}, cx_r} + {1'b0, accx_r});
    smpy_w = negy_r ? ({{2{cy_r[COORD_W-1]}}, cy_r} - {1'b0, accy_r})
                    : ({{2{cy_r[COORD_W-1]}}, cy_r} + {1'b0, accy_r});
    if (cnt_r == '0) begin
      smp_x = cx_r;
      smp_y = cy_r;
    end else if (cnt_r == n_r) begin
      smp_x = sx_r;
      smp_y = sy_r;
    end else begin
      smp_x = smpx_w[COORD_W-1:0];
      smp_y = smpy_w[COORD_W-1:0];
    end
  end

  // Select what enters the distance pipeline
  always_comb begin
    d_in_valid = 1'b0;
    d_ax       = qx_r;
    d_ay       = qy_r;
    d_bx       = rd_data_r[COORD_W-1:0];
    d_by       = rd_data_r[2*COORD_W-1:COORD_W];
    d_tag.idx  = rd_idx_r;
    d_tag.x    = rd_data_r[COORD_W-1:0];
    d_tag.y    = rd_data_r[2*COORD_W-1:COORD_W];
    case (state_r)
      S_SCAN: d_in_valid = rd_v_r;
      S_SEG: begin
        d_in_valid = (cnt_r == '0);
        d_ax       = cx_r;
        d_ay       = cy_r;
        d_bx       = sx_r;
        d_by       = sy_r;
      end
      S_SAMP: begin
        d_in_valid = samp_issue;
        d_bx       = smp_x;
        d_by       = smp_y;
        d_tag.x    = smp_x;
        d_tag.y    = smp_y;
      end
      default: d_in_valid = 1'b0;
    endcase
  end

  npps_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_in_valid),
    .ax        (d_ax),
    .ay        (d_ay),
    .bx        (d_bx),
    .by        (d_by),
    .in_tag    (d_tag),
    .out_valid (d_out_valid),
    .out_dist  (d_out_dist),
    .out_tag   (d_out_tag)
  );

  // Path store: one write or one registered read a cycle
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && item_valid && item.op == OP_WRITE) begin
      mem[item.idx] <= {item.y, item.x};
    end
    if (scan_issue) begin
      rd_data_r <= mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      rd_v_r <= scan_issue;
      // Drop a taken result unless the next one loads in the same cycle
      if (res_valid_r && res_ready && state_r != S_DONE) res_valid_r <= 1'b0;

      case (state_r)
        // Take one queued transaction
        S_IDLE: begin
          if (item_valid && item.op == OP_QUERY) begin
            qx_r  <= item.x;
            qy_r  <= item.y;
            len_r <= (path_length > LEN_MAX) ? LEN_MAX : path_length;
            cnt_r <= '0;
            rc_r  <= '0;
            cd_r  <= DIST_MAX;
            sd_r  <= DIST_MAX;
            if (path_length == '0) begin
              pend_r  <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end

        // Track nearest and second-nearest waypoints
        S_SCAN: begin
          if (scan_issue) cnt_r <= cnt_r + NS_W'(1);
          if (d_out_valid) begin
            rc_r <= rc_r + NS_W'(1);
            if (d66 < cd_r) begin
              sd_r <= cd_r;
              si_r <= ci_r;
              sx_r <= cx_r;
              sy_r <= cy_r;
              cd_r <= d66;
              ci_r <= d_out_tag.idx;
              cx_r <= d_out_tag.x;
              cy_r <= d_out_tag.y;
            end else if (d66 < sd_r) begin
              sd_r <= d66;
              si_r <= d_out_tag.idx;
              sx_r <= d_out_tag.x;
              sy_r <= d_out_tag.y;
            end
          end
          if (rc_r == {2'b0, len_r}) begin
            if (len_r == LEN_W'(1)) begin
              pend_r.found                  <= 1'b0;
              pend_r.single_point           <= 1'b1;
              pend_r.result_x               <= cx_r;
              pend_r.result_y               <= cy_r;
              pend_r.nearest_waypoint_index <= '0;
              pend_r.second_waypoint_index  <= '0;
              pend_r.nearest_above_second   <= 1'b0;
              state_r                       <= S_DONE;
            end else begin
              cnt_r   <= '0;
              state_r <= S_SEG;
            end
          end
        end

        // Squared length of the segment
        S_SEG: begin
          if (cnt_r == '0) cnt_r <= NS_W'(1);
          if (d_out_valid) begin
            rad_r   <= d66;
            rem_r   <= '0;
            root_r  <= '0;
            step_r  <= 6'(ROOT_W);
            state_r <= S_SQRT;
          end
        end

        // Integer square root, one result bit a cycle
        S_SQRT: begin
          rem_r  <= rem_ge ? rem_t - trial : rem_t;
          root_r <= {root_r[ROOT_W-2:0], rem_ge};
          rad_r  <= {rad_r[CMP_W-3:0], 2'b00};
          step_r <= step_r - 6'd1;
          if (step_r == 6'd1) state_r <= S_NCALC;
        end

        S_NCALC: begin
          prod_r  <= root_r * sample_density;
          state_r <= S_NSAT;
        end

        // Fix n and load the two dividers
        S_NSAT: begin
          n_r     <= n_sat;
          negx_r  <= sdx[COORD_W];
          negy_r  <= sdy[COORD_W];
          numx_r  <= {amx[COORD_W-1:0], 1'b0};
          numy_r  <= {amy[COORD_W-1:0], 1'b0};
          quox_r  <= '0;
          quoy_r  <= '0;
          drx_r   <= '0;
          dry_r   <= '0;
          step_r  <= 6'(NUM_W);
          state_r <= S_DIV;
        end

        // Restoring divide of twice the delta by twice n
        S_DIV: begin
          numx_r <= {numx_r[NUM_W-2:0], 1'b0};
          numy_r <= {numy_r[NUM_W-2:0], 1'b0};
          if (rrx >= {1'b0, dvsr}) begin
            drx_r  <= DV_W'(rrx - {1'b0, dvsr});
            quox_r <= {quox_r[NUM_W-2:0], 1'b1};
          end else begin
            drx_r  <= rrx[DV_W-1:0];
            quox_r <= {quox_r[NUM_W-2:0], 1'b0};
          end
          if (rry >= {1'b0, dvsr}) begin
            dry_r  <= DV_W'(rry - {1'b0, dvsr});
            quoy_r <= {quoy_r[NUM_W-2:0], 1'b1};
          end else begin
            dry_r  <= rry[DV_W-1:0];
            quoy_r <= {quoy_r[NUM_W-2:0], 1'b0};
          end
          step_r <= step_r - 6'd1;
          if (step_r == 6'd1) begin
            cnt_r   <= '0;
            rc_r    <= '0;
            bd_r    <= DIST_MAX;
            accx_r  <= '0;
            accy_r  <= '0;
            smx_r   <= {2'b0, n_r};
            smy_r   <= {2'b0, n_r};
            state_r <= S_SAMP;
          end
        end

        // Walk the samples and keep the nearest
        S_SAMP: begin
          if (samp_issue) begin
            cnt_r <= cnt_r + NS_W'(1);
            if (stx >= {1'b0, dvsr}) begin
              smx_r  <= stx - {1'b0, dvsr};
              accx_r <= accx_r + quox_r + NUM_W'(1);
            end else begin
              smx_r  <= stx;
              accx_r <= accx_r + quox_r;
            end
            if (sty >= {1'b0, dvsr}) begin
              smy_r  <= sty - {1'b0, dvsr};
              accy_r <= accy_r + quoy_r + NUM_W'(1);
            end else begin
              smy_r  <= sty;
              accy_r <= accy_r + quoy_r;
            end
          end
          if (d_out_valid) begin
            rc_r <= rc_r + NS_W'(1);
            if (d66 < bd_r) begin
              bd_r <= d66;
              bx_r <= d_out_tag.x;
              by_r <= d_out_tag.y;
            end
          end
          if (rc_r == n_r + NS_W'(1)) begin
            pend_r.found                  <= 1'b1;
            pend_r.single_point           <= 1'b0;
            pend_r.result_x               <= bx_r;
            pend_r.result_y               <= by_r;
            pend_r.nearest_waypoint_index <= ci_r;
            pend_r.second_waypoint_index  <= si_r;
            pend_r.nearest_above_second   <= (ci_r > si_r);
            state_r                       <= S_DONE;
          end
        end

        // Hand the result to the output register
        S_DONE: begin
          if (!res_valid_r || res_ready) begin
            res_r       <= pend_r;
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule

// File: rtl/nearest_path_point_search.sv
// Top level of the nearest path point search: configuration and channel wiring.
//
//   channel | dir | handshake        | carries
//   --------+-----+------------------+-----------------------------------------
//   in_if   | in  | valid/ready      | req_type, waypoint_index, ref_x, ref_y
//   out_if  | out | valid/ready      | found, single_point, result_x/y, indexes
//   cfg_*   | in  | cfg_we, no wait  | path_length, sample_density
//
// A waypoint write is stored straight from the queue while the engine is idle.
// A query with two or more waypoints reads its len waypoints one a cycle from
// the single store port, then takes 33 square root steps and 33 divide steps
// and passes n+1 samples through the shared distance pipeline before its
// result is registered. Reset is synchronous; the path store is not cleared.
// A two-entry queue keeps requests flowing while the engine works, and the
// output register holds a result until taken.
module nearest_path_point_search (
  input  logic                             clk,
  input  logic                             rst_n,
  npps_in_if.sink                          in_if,
  npps_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  logic [npps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [npps_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import npps_pkg::*;

  logic [LEN_W-1:0]  path_length_r;
  logic [DENS_W-1:0] sample_density_r;
  item_t             item;
  logic              item_valid;
  logic              item_ready;
  result_t           res;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_length_r    <= '0;
      sample_density_r <= DENSITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATH_LENGTH:    path_length_r    <= cfg_wdata[LEN_W-1:0];
        REG_SAMPLE_DENSITY: sample_density_r <= cfg_wdata[DENS_W-1:0];
        default:            path_length_r    <= path_length_r;
      endcase
    end
  end

  npps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  npps_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (item),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .path_length    (path_length_r),
    .sample_density (sample_density_r),
    .res            (res),
    .res_valid      (out_if.valid),
    .res_ready      (out_if.ready)
  );

  assign out_if.found                  = res.found;
  assign out_if.single_point           = res.single_point;
  assign out_if.result_x               = res.result_x;
  assign out_if.result_y               = res.result_y;
  assign out_if.nearest_waypoint_index = res.nearest_waypoint_index;
  assign out_if.second_waypoint_index  = res.second_waypoint_index;
  assign out_if.nearest_above_second   = res.nearest_above_second;

endmodule

// File: rtl/npps_checker.sv
// Port-level checker for the nearest path point search, bound to the top level.
module npps_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                found,
  input logic                                single_point,
  input logic signed [npps_pkg::COORD_W-1:0] result_x,
  input logic signed [npps_pkg::COORD_W-1:0] result_y,
  input logic [npps_pkg::IDX_W-1:0]          nearest_idx,
  input logic [npps_pkg::IDX_W-1:0]          second_idx,
  input logic                                nearest_above_second
);

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(result_x) && $stable(result_y))
    else $error("result changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(found && single_point))
    else $error("found and single_point both set");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> (nearest_above_second == (nearest_idx > second_idx))
                           && (nearest_idx != second_idx))
    else $error("index order flag wrong");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> nearest_idx == '0 && second_idx == '0 && !nearest_above_second)
    else $error("index fields set without a segment");

endmodule

bind nearest_path_point_search npps_checker u_npps_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_if.valid),
  .out_ready            (out_if.ready),
  .found                (out_if.found),
  .single_point         (out_if.single_point),
  .result_x             (out_if.result_x),
  .result_y             (out_if.result_y),
  .nearest_idx          (out_if.nearest_waypoint_index),
  .second_idx           (out_if.second_waypoint_index),
  .nearest_above_second (out_if.nearest_above_second)
);
